// ----- rtl/core/uart_baud_divisor_search_macros.svh -----
// Assertion macros used by the baud divisor search RTL.
`ifndef UART_BAUD_DIVISOR_SEARCH_MACROS_SVH
`define UART_BAUD_DIVISOR_SEARCH_MACROS_SVH
`ifndef SYNTHESIS
`define UBDS_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define UBDS_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define UBDS_ASSERT_IMP(label, clk, rst, pre, post)
`define UBDS_ASSERT_NXT(label, clk, rst, pre, post)
`endif
`endif

// ----- rtl/core/ubds_pkg.sv -----
package ubds_pkg;
   localparam int BAUD_W     = 23;
   localparam int CLK_W      = 28;
   localparam int RATIO_W    = 6;
   localparam int DIV_OUT_W  = 13;
   localparam logic [CLK_W-1:0] CLOCK_RESET = 28'd24000000;
   localparam int BOTH_EDGE_MAX = 8;
endpackage

// ----- rtl/core/ubds_req_if.sv -----
interface ubds_req_if;
   logic                         valid;
   logic                         ready;
   logic [ubds_pkg::BAUD_W-1:0]  bit_rate;
   modport source (output valid, output bit_rate, input ready);
   modport sink (input valid, input bit_rate, output ready);
endinterface

// ----- rtl/core/ubds_rsp_if.sv -----
interface ubds_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ubds_pkg::RATIO_W-1:0]    oversample_ratio;
   logic [ubds_pkg::DIV_OUT_W-1:0]  divisor;
   logic                            both_edge;
   modport source (output valid, output oversample_ratio, output divisor,
                   output both_edge, input ready);
   modport sink (input valid, input oversample_ratio, input divisor,
                 input both_edge, output ready);
endinterface

// ----- rtl/core/ubds_cell.sv -----
module ubds_cell #(
   parameter int OSR         = 4,
   parameter int MAX_DIVISOR = 8191,
   parameter int OSR_W       = 6,
   parameter int DIV_W       = 13,
   parameter int ERR_W       = 42
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic [ubds_pkg::CLK_W-1:0]  clock_hz,
   input  logic                        in_valid,
   input  logic [ubds_pkg::BAUD_W-1:0] in_baud,
   input  logic                        in_have,
   input  logic [ERR_W-1:0]            in_err,
   input  logic [DIV_W-1:0]            in_div,
   input  logic [OSR_W-1:0]            in_osr,
   output logic                        out_valid,
   output logic [ubds_pkg::BAUD_W-1:0] out_baud,
   output logic                        out_have,
   output logic [ERR_W-1:0]            out_err,
   output logic [DIV_W-1:0]            out_div,
   output logic [OSR_W-1:0]            out_osr
);
   localparam int DEN_W = ubds_pkg::BAUD_W + OSR_W;
   localparam int W     = DEN_W + DIV_W + 2;
   localparam int NS    = DIV_W + 2;

   logic                        v_ff    [0:NS-1];
   logic                        v_in    [0:NS-1];
   logic [ubds_pkg::BAUD_W-1:0] baud_ff [0:NS-1];
   logic [ubds_pkg::BAUD_W-1:0] baud_in [0:NS-1];
   logic                        have_ff [0:NS-1];
   logic                        have_in [0:NS-1];
   logic [ERR_W-1:0]            berr_ff [0:NS-1];
   logic [ERR_W-1:0]            berr_in [0:NS-1];
   logic [DIV_W-1:0]            bdiv_ff [0:NS-1];
   logic [DIV_W-1:0]            bdiv_in [0:NS-1];
   logic [OSR_W-1:0]            bosr_ff [0:NS-1];
   logic [OSR_W-1:0]            bosr_in [0:NS-1];
   logic [DEN_W-1:0]            den_ff  [0:DIV_W];
   logic [DEN_W-1:0]            den_in  [0:DIV_W];
   logic [W-1:0]                rem_ff  [0:DIV_W];
   logic [W-1:0]                rem_in  [0:DIV_W];
   logic [DIV_W-1:0]            q_ff    [0:DIV_W];
   logic [DIV_W-1:0]            q_in    [0:DIV_W];
   logic                        ovf_ff  [0:DIV_W];
   logic                        ovf_in  [0:DIV_W];
   logic [ERR_W-1:0]            prod_ff;
   logic [ERR_W-1:0]            prod_in;
   logic [DIV_W-1:0]            div_ff;
   logic [DIV_W-1:0]            div_in;
   logic [DIV_W-1:0]            div_sel;
   logic [ERR_W-1:0]            clk_ext;
   logic [ERR_W-1:0]            err;
   logic                        take;
   logic [W-1:0]                dsh;
   logic                        out_valid_ff, out_have_ff;
   logic [ubds_pkg::BAUD_W-1:0] out_baud_ff;
   logic [ERR_W-1:0]            out_err_ff;
   logic [DIV_W-1:0]            out_div_ff;
   logic [OSR_W-1:0]            out_osr_ff;

   always_comb begin
      v_in[0]    = in_valid;
      baud_in[0] = in_baud;
      have_in[0] = in_have;
      berr_in[0] = in_err;
      bdiv_in[0] = in_div;
      bosr_in[0] = in_osr;
      den_in[0]  = DEN_W'(in_baud) * DEN_W'(OSR);
      rem_in[0]  = W'({clock_hz, 1'b0}) + W'(den_in[0]);
      ovf_in[0]  = rem_in[0] >= (W'(den_in[0]) << (DIV_W + 1));
      q_in[0]    = '0;
      for (int k = 1; k < NS; k++) begin
         v_in[k]    = v_ff[k-1];
         baud_in[k] = baud_ff[k-1];
         have_in[k] = have_ff[k-1];
         berr_in[k] = berr_ff[k-1];
         bdiv_in[k] = bdiv_ff[k-1];
         bosr_in[k] = bosr_ff[k-1];
      end
      for (int k = 1; k <= DIV_W; k++) begin
         dsh       = W'(den_ff[k-1]) << (DIV_W - k + 1);
         den_in[k] = den_ff[k-1];
         ovf_in[k] = ovf_ff[k-1];
         if (rem_ff[k-1] >= dsh) begin
            rem_in[k] = rem_ff[k-1] - dsh;
            q_in[k]   = q_ff[k-1] | (DIV_W'(1) << (DIV_W - k));
         end else begin
            rem_in[k] = rem_ff[k-1];
            q_in[k]   = q_ff[k-1];
         end
      end
   end

   always_comb begin
      if (ovf_ff[DIV_W] || (q_ff[DIV_W] > DIV_W'(MAX_DIVISOR))) begin
         div_sel = DIV_W'(MAX_DIVISOR);
      end else if (q_ff[DIV_W] == '0) begin
         div_sel = DIV_W'(1);
      end else begin
         div_sel = q_ff[DIV_W];
      end
      div_in  = div_sel;
      prod_in = ERR_W'(div_sel) * ERR_W'(den_ff[DIV_W]);
      clk_ext = ERR_W'(clock_hz);
      err     = (prod_ff >= clk_ext) ? (prod_ff - clk_ext) : (clk_ext - prod_ff);
      take    = !have_ff[NS-1] || (err <= berr_ff[NS-1]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NS; k++) begin
            baud_ff[k] <= baud_in[k];
            have_ff[k] <= have_in[k];
            berr_ff[k] <= berr_in[k];
            bdiv_ff[k] <= bdiv_in[k];
            bosr_ff[k] <= bosr_in[k];
         end
         for (int k = 0; k <= DIV_W; k++) begin
            den_ff[k] <= den_in[k];
            rem_ff[k] <= rem_in[k];
            q_ff[k]   <= q_in[k];
            ovf_ff[k] <= ovf_in[k];
         end
         prod_ff     <= prod_in;
         div_ff      <= div_in;
         out_baud_ff <= baud_ff[NS-1];
         out_have_ff <= 1'b1;
         out_err_ff  <= take ? err : berr_ff[NS-1];
         out_div_ff  <= take ? div_ff : bdiv_ff[NS-1];
         out_osr_ff  <= take ? OSR_W'(OSR) : bosr_ff[NS-1];
      end
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            v_ff[k] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (en) begin
         for (int k = 0; k < NS; k++) begin
            v_ff[k] <= v_in[k];
         end
         out_valid_ff <= v_ff[NS-1];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_baud  = out_baud_ff;
   assign out_have  = out_have_ff;
   assign out_err   = out_err_ff;
   assign out_div   = out_div_ff;
   assign out_osr   = out_osr_ff;
endmodule

// ----- rtl/core/uart_baud_divisor_search.sv -----
// Throughput: one item per cycle; each ratio cell runs a one-bit-per-stage divider.
// The whole chain holds while a finished item waits on the result channel.
// Reset is synchronous and active high; it empties the chain and sets the
// clock register to 24000000.
`include "uart_baud_divisor_search_macros.svh"
module uart_baud_divisor_search #(
   parameter int MIN_OVERSAMPLE = 4,
   parameter int MAX_OVERSAMPLE = 32,
   parameter int MAX_DIVISOR    = 8191
) (
   input  logic                       clock,
   input  logic                       reset,
   ubds_req_if.sink                   req_chan,
   ubds_rsp_if.source                 rsp_chan,
   input  logic                       csr_wr_en,
   input  logic [ubds_pkg::CLK_W-1:0] csr_wr_data
);
   localparam int NCELL = MAX_OVERSAMPLE - MIN_OVERSAMPLE + 1;
   localparam int OSR_W = $clog2(MAX_OVERSAMPLE + 1);
   localparam int DIV_W = $clog2(MAX_DIVISOR + 1);
   localparam int ERR_W = DIV_W + ubds_pkg::BAUD_W + OSR_W;

   logic [ubds_pkg::CLK_W-1:0]  clock_hz_ff;
   logic                        en;
   logic                        c_valid [0:NCELL];
   logic [ubds_pkg::BAUD_W-1:0] c_baud  [0:NCELL];
   logic                        c_have  [0:NCELL];
   logic [ERR_W-1:0]            c_err   [0:NCELL];
   logic [DIV_W-1:0]            c_div   [0:NCELL];
   logic [OSR_W-1:0]            c_osr   [0:NCELL];

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= ubds_pkg::CLOCK_RESET;
      end else if (csr_wr_en) begin
         clock_hz_ff <= csr_wr_data;
      end
   end

   assign en             = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = en;
   assign c_valid[0]     = req_chan.valid;
   assign c_baud[0]      = req_chan.bit_rate;
   assign c_have[0]      = 1'b0;
   assign c_err[0]       = '0;
   assign c_div[0]       = DIV_W'(1);
   assign c_osr[0]       = OSR_W'(MIN_OVERSAMPLE);

   for (genvar g = 0; g < NCELL; g++) begin : g_cell
      ubds_cell #(
         .OSR         (MIN_OVERSAMPLE + g),
         .MAX_DIVISOR (MAX_DIVISOR),
         .OSR_W       (OSR_W),
         .DIV_W       (DIV_W),
         .ERR_W       (ERR_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .clock_hz  (clock_hz_ff),
         .in_valid  (c_valid[g]),
         .in_baud   (c_baud[g]),
         .in_have   (c_have[g]),
         .in_err    (c_err[g]),
         .in_div    (c_div[g]),
         .in_osr    (c_osr[g]),
         .out_valid (c_valid[g+1]),
         .out_baud  (c_baud[g+1]),
         .out_have  (c_have[g+1]),
         .out_err   (c_err[g+1]),
         .out_div   (c_div[g+1]),
         .out_osr   (c_osr[g+1])
      );
   end

   assign rsp_chan.valid            = c_valid[NCELL];
   assign rsp_chan.oversample_ratio = ubds_pkg::RATIO_W'(c_osr[NCELL]);
   assign rsp_chan.divisor          = ubds_pkg::DIV_OUT_W'(c_div[NCELL]);
   assign rsp_chan.both_edge        = c_osr[NCELL] <= OSR_W'(ubds_pkg::BOTH_EDGE_MAX);

   `UBDS_ASSERT_IMP(a_stall_holds_input, clock, reset, rsp_chan.valid && !rsp_chan.ready, !req_chan.ready)
   `UBDS_ASSERT_IMP(a_div_range, clock, reset, rsp_chan.valid, (c_div[NCELL] >= DIV_W'(1)) && (c_div[NCELL] <= DIV_W'(MAX_DIVISOR)))
   `UBDS_ASSERT_IMP(a_osr_range, clock, reset, rsp_chan.valid, (c_osr[NCELL] >= OSR_W'(MIN_OVERSAMPLE)) && (c_osr[NCELL] <= OSR_W'(MAX_OVERSAMPLE)))
   `UBDS_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_chan.valid)
endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   localparam int RATIO_LO    = 4;
   localparam int RATIO_HI    = 32;
   localparam int DIV_LIMIT   = 8191;
   localparam int LATENCY     = 464;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS_PER_PHASE = 80;
   localparam int HOLD_PHASE_ITEMS = 200;
   localparam int HOLD_PHASE  = 2;
   localparam int NUM_PHASES  = 6;

   typedef struct packed {
      logic [ubds_pkg::RATIO_W-1:0]   ratio;
      logic [ubds_pkg::DIV_OUT_W-1:0] divisor;
      logic                           both_edge;
   } baud_setting_type;

   typedef struct {
      logic [ubds_pkg::BAUD_W-1:0]    baud;
      bit                             typed;
      logic [ubds_pkg::RATIO_W-1:0]   ratio;
      logic [ubds_pkg::DIV_OUT_W-1:0] divisor;
      logic                           both_edge;
   } baud_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [ubds_pkg::CLK_W-1:0] csr_wr_data = '0;

   ubds_req_if req_chan ();
   ubds_rsp_if rsp_chan ();

   uart_baud_divisor_search dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan.sink),
      .rsp_chan   (rsp_chan.source),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   logic [ubds_pkg::CLK_W-1:0] model_clock_hz;
   baud_setting_type pending_settings[$];
   int               fail_count = 0;
   int               cycle_count = 0;
   int               src_idle_pct = 0;
   int               snk_idle_pct = 0;
   int               rsp_hold_left = 0;

   baud_row_type directed_rows[] = '{
      '{23'd0,        1'b1, 6'd32, 13'd8191, 1'b0},
      '{23'h7FFFFF,   1'b1, 6'd4,  13'd1,    1'b1},
      '{23'd1,        1'b0, '0, '0, 1'b0},
      '{23'd2,        1'b0, '0, '0, 1'b0},
      '{23'd300,      1'b0, '0, '0, 1'b0},
      '{23'd9600,     1'b0, '0, '0, 1'b0},
      '{23'd57600,    1'b0, '0, '0, 1'b0},
      '{23'd115200,   1'b0, '0, '0, 1'b0},
      '{23'd921600,   1'b0, '0, '0, 1'b0},
      '{23'd1500000,  1'b0, '0, '0, 1'b0},
      '{23'd3000000,  1'b0, '0, '0, 1'b0},
      '{23'd4000000,  1'b0, '0, '0, 1'b0},
      '{23'd6000000,  1'b0, '0, '0, 1'b0},
      '{23'h555555,   1'b0, '0, '0, 1'b0},
      '{23'h2AAAAA,   1'b0, '0, '0, 1'b0}
   };

   function automatic baud_setting_type best_baud_setting(
         logic [ubds_pkg::BAUD_W-1:0] baud, logic [ubds_pkg::CLK_W-1:0] clk_hz);
      longint unsigned b;
      longint unsigned c;
      longint unsigned r_u;
      longint unsigned lim;
      longint unsigned den;
      longint unsigned div;
      longint unsigned prod;
      longint unsigned err;
      longint unsigned best_err;
      int              best_ratio;
      longint unsigned best_div;
      baud_setting_type res;
      b = 64'(baud);
      c = 64'(clk_hz);
      lim = 64'(DIV_LIMIT);
      best_err = 64'd0;
      best_ratio = RATIO_LO;
      best_div = 64'd1;
      for (int r = RATIO_LO; r <= RATIO_HI; r++) begin
         r_u = 64'(r);
         if (b == 64'd0) begin
            div = lim;
         end else begin
            den = b * r_u;
            div = (64'd2 * c + den) / (64'd2 * den);
            if (div < 64'd1) div = 64'd1;
            else if (div > lim) div = lim;
         end
         prod = div * r_u * b;
         err = (prod >= c) ? prod - c : c - prod;
         if (r == RATIO_LO || err <= best_err) begin
            best_err = err;
            best_div = div;
            best_ratio = r;
         end
      end
      res.ratio = best_ratio[ubds_pkg::RATIO_W-1:0];
      res.divisor = best_div[ubds_pkg::DIV_OUT_W-1:0];
      res.both_edge = (best_ratio <= ubds_pkg::BOTH_EDGE_MAX);
      return res;
   endfunction

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("uart_baud_divisor_search test failed");
         $finish;
      end
   end

   initial begin
      rsp_chan.ready = 1'b0;
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
   end

   always @(posedge clock) begin
      baud_setting_type exp_s;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_settings.size() == 0) begin
            $error("unexpected item: ratio %0d divisor %0d", rsp_chan.oversample_ratio,
                   rsp_chan.divisor);
            fail_count++;
         end else begin
            exp_s = pending_settings.pop_front();
            if (rsp_chan.oversample_ratio !== exp_s.ratio) begin
               $error("oversample_ratio: expected %0d, actual %0d", exp_s.ratio,
                      rsp_chan.oversample_ratio);
               fail_count++;
            end
            if (rsp_chan.divisor !== exp_s.divisor) begin
               $error("divisor: expected %0d, actual %0d", exp_s.divisor, rsp_chan.divisor);
               fail_count++;
            end
            if (rsp_chan.both_edge !== exp_s.both_edge) begin
               $error("both_edge: expected %0d, actual %0d", exp_s.both_edge,
                      rsp_chan.both_edge);
               fail_count++;
            end
         end
      end
   end

   task automatic send_baud(logic [ubds_pkg::BAUD_W-1:0] baud, baud_setting_type exp_s);
      while ($urandom_range(99) < src_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.bit_rate <= baud;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      pending_settings.push_back(exp_s);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (pending_settings.size() != 0) @(negedge clock);
   endtask

   task automatic write_clock(logic [ubds_pkg::CLK_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      model_clock_hz = value;
   endtask

   function automatic logic [ubds_pkg::BAUD_W-1:0] random_baud();
      case ($urandom_range(3))
         0: return ubds_pkg::BAUD_W'($urandom());
         1: return ubds_pkg::BAUD_W'($urandom_range(6000000, 1));
         2: return ubds_pkg::BAUD_W'($urandom_range(255));
         default: return ubds_pkg::BAUD_W'($urandom_range(6000000, 1000000));
      endcase
   endfunction

   initial begin
      logic [ubds_pkg::CLK_W-1:0] phase_clocks[NUM_PHASES];
      logic [ubds_pkg::BAUD_W-1:0] b;
      baud_setting_type exp_s;
      int n_items;
      req_chan.valid = 1'b0;
      req_chan.bit_rate = '0;
      model_clock_hz = ubds_pkg::CLOCK_RESET;
      phase_clocks = '{28'd1000000, 28'd200000000, 28'hFFFFFFF, 28'd0, 28'd0, 28'd48000000};
      phase_clocks[4] = ubds_pkg::CLK_W'($urandom_range(200000000, 1000000));
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      src_idle_pct = 6;
      snk_idle_pct = 65;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].typed) begin
            exp_s.ratio = directed_rows[i].ratio;
            exp_s.divisor = directed_rows[i].divisor;
            exp_s.both_edge = directed_rows[i].both_edge;
         end else begin
            exp_s = best_baud_setting(directed_rows[i].baud, model_clock_hz);
         end
         send_baud(directed_rows[i].baud, exp_s);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_results();
         write_clock(phase_clocks[p]);
         if (p == 2) begin
            src_idle_pct = 65;
            snk_idle_pct = 6;
         end else if (p == 4) begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
         end
         n_items = RANDOM_ITEMS_PER_PHASE;
         if (p == HOLD_PHASE) begin
            rsp_hold_left = 3000;
            n_items = HOLD_PHASE_ITEMS;
         end
         for (int n = 0; n < n_items; n++) begin
            b = random_baud();
            send_baud(b, best_baud_setting(b, model_clock_hz));
         end
      end

      drain_results();
      repeat (LATENCY + 50) @(negedge clock);
      if (fail_count == 0) begin
         $display("uart_baud_divisor_search test passed");
      end else begin
         $display("uart_baud_divisor_search test failed");
      end
      $finish;
   end
endmodule
